>>> rtl/ssdmux_pkg.sv
package ssdmux_pkg;

    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [2:0] FN_INIT    = 3'd0;
    localparam logic [2:0] FN_BLANK   = 3'd1;
    localparam logic [2:0] FN_DECIMAL = 3'd2;
    localparam logic [2:0] FN_HEX     = 3'd3;
    localparam logic [2:0] FN_RAW     = 3'd4;
    localparam logic [2:0] FN_TICK    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_ACTIVE_HIGH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIG_ACTIVE_HIGH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_PIN_MAP     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIG_PIN_MAP     = 4'd3;

    localparam logic [23:0] SEG_PIN_MAP_RST = 24'd342391;
    localparam logic [11:0] DIG_PIN_MAP_RST = 12'd1672;

    localparam logic [15:0] MAX_DECIMAL = 16'd9999;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_INIT  = 3'd1,
        OP_BLANK = 3'd2,
        OP_WRITE = 3'd3,
        OP_TICK  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [NUM_DIGITS-1:0]       wr_mask;
        logic [NUM_DIGITS-1:0][7:0]  pat;
    } cmd_t;

    typedef struct packed {
        logic        seg_ah;
        logic        dig_ah;
        logic [23:0] seg_map;
        logic [11:0] dig_map;
    } cfg_t;

    typedef struct packed {
        logic [7:0] segment_lines;
        logic [7:0] digit_lines;
        logic [7:0] digit_pin_mask;
        logic [1:0] next_digit;
    } res_t;

    function automatic logic [7:0] glyph(input logic [3:0] nib);
        logic [7:0] g;
        case (nib)
            4'h0:    g = 8'hFC;
            4'h1:    g = 8'h60;
            4'h2:    g = 8'hDA;
            4'h3:    g = 8'hF2;
            4'h4:    g = 8'h66;
            4'h5:    g = 8'hB6;
            4'h6:    g = 8'hBE;
            4'h7:    g = 8'hE0;
            4'h8:    g = 8'hFE;
            4'h9:    g = 8'hF6;
            4'hA:    g = 8'hEE;
            4'hB:    g = 8'h3E;
            4'hC:    g = 8'h9C;
            4'hD:    g = 8'h7A;
            4'hE:    g = 8'h9E;
            default: g = 8'h8E;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/ssdmux_front.sv
module ssdmux_front
    import ssdmux_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] func,
    input  logic [15:0] value,
    input  logic [2:0] dp_position,
    input  logic [2:0] digit_position,
    input  logic [7:0] logical_pattern,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam logic [14:0] RECIP_1000 = 15'd16778;

    logic [13:0] dec_val;
    logic [29:0] prod_10;
    logic [26:0] prod_100;
    logic [28:0] prod_1000;
    logic [9:0]  quo_10;
    logic [6:0]  quo_100;
    logic [3:0]  quo_1000;
    logic [3:0]  dec_digit [NUM_DIGITS];
    logic        push_ok;
    cmd_t        cmd_new;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    // decimal split by reciprocal multiplication
    always_comb
    begin
        dec_val   = (value > MAX_DECIMAL) ? MAX_DECIMAL[13:0] : value[13:0];
        prod_10   = 30'(dec_val) * 30'(RECIP_10);
        prod_100  = 27'(dec_val) * 27'(RECIP_100);
        prod_1000 = 29'(dec_val) * 29'(RECIP_1000);
        quo_10    = prod_10[28:19];
        quo_100   = prod_100[25:19];
        quo_1000  = prod_1000[27:24];
        dec_digit[0] = 4'(dec_val - 14'(quo_10) * 14'd10);
        dec_digit[1] = 4'(quo_10 - 10'(quo_100) * 10'd10);
        dec_digit[2] = 4'(quo_100 - 7'(quo_1000) * 7'd10);
        dec_digit[3] = quo_1000;
    end

    always_comb
    begin
        cmd_new.op      = OP_NOP;
        cmd_new.wr_mask = '0;
        cmd_new.pat     = '0;
        case (func)
            FN_INIT:
            begin
                cmd_new.op = OP_INIT;
            end
            FN_BLANK:
            begin
                cmd_new.op = OP_BLANK;
            end
            FN_DECIMAL:
            begin
                cmd_new.op      = OP_WRITE;
                cmd_new.wr_mask = '1;
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    cmd_new.pat[i] = glyph(dec_digit[i])
                                   | {7'b0, dp_position == 3'(i)};
                end
            end
            FN_HEX:
            begin
                cmd_new.op      = OP_WRITE;
                cmd_new.wr_mask = '1;
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    cmd_new.pat[i] = glyph(value[4*i +: 4]);
                end
            end
            FN_RAW:
            begin
                if (!digit_position[2])
                begin
                    cmd_new.op      = OP_WRITE;
                    cmd_new.wr_mask = 4'b0001 << digit_position[1:0];
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        cmd_new.pat[i] = logical_pattern;
                    end
                end
            end
            FN_TICK:
            begin
                cmd_new.op = OP_TICK;
            end
            default:
            begin
                cmd_new.op = OP_NOP;
            end
        endcase
    end

    // two-word command queue
    assign full      = (cnt_reg == 2'd2);
    assign push_ok   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push_ok) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("command queue count out of range");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !cmd_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("command queue lost a word");

endmodule

>>> rtl/ssdmux_back.sv
module ssdmux_back
    import ssdmux_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic empty,
    input  logic pop,
    output res_t res
);

    logic [7:0] pat_reg [NUM_DIGITS];
    logic [7:0] pat_next [NUM_DIGITS];
    logic [1:0] scan_index_reg, scan_index_next;
    logic [7:0] seg_hold_reg, seg_hold_next;
    logic [7:0] dig_hold_reg, dig_hold_next;

    res_t       rq_reg [2];
    logic       rq_wr_ptr_reg, rq_wr_ptr_next;
    logic       rq_rd_ptr_reg, rq_rd_ptr_next;
    logic [1:0] rq_cnt_reg, rq_cnt_next;
    logic       rq_full;
    logic       rq_pop;

    logic       exec;
    logic [7:0] blank;
    logic [7:0] dig_bit [NUM_DIGITS];
    logic [7:0] dig_mask;
    logic [7:0] off_hold;
    logic [7:0] cur_bit;
    res_t       res_new;

    function automatic logic [7:0] to_phys(input logic [7:0] lg, input cfg_t c);
        logic [7:0] lit;
        lit = '0;
        for (int s = 0; s < 8; s++)
        begin
            if (lg[7-s])
            begin
                lit = lit | (8'b1 << c.seg_map[3*s +: 3]);
            end
        end
        return c.seg_ah ? lit : ~lit;
    endfunction

    assign rq_full = (rq_cnt_reg == 2'd2);
    assign exec    = cmd_valid && !rq_full;
    assign cmd_pop = exec;
    assign blank   = cfg.seg_ah ? 8'h00 : 8'hFF;

    always_comb
    begin
        dig_mask = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            dig_bit[i] = 8'b1 << cfg.dig_map[3*i +: 3];
            dig_mask   = dig_mask | dig_bit[i];
        end
        off_hold = cfg.dig_ah ? (dig_hold_reg & ~dig_mask) : (dig_hold_reg | dig_mask);
        cur_bit  = dig_bit[scan_index_reg];
    end

    always_comb
    begin
        pat_next        = pat_reg;
        scan_index_next = scan_index_reg;
        seg_hold_next   = seg_hold_reg;
        dig_hold_next   = dig_hold_reg;
        if (exec)
        begin
            case (cmd.op)
                OP_INIT:
                begin
                    seg_hold_next = blank;
                    dig_hold_next = off_hold;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        pat_next[i] = blank;
                    end
                end
                OP_BLANK:
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        pat_next[i] = blank;
                    end
                end
                OP_WRITE:
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        if (cmd.wr_mask[i])
                        begin
                            pat_next[i] = to_phys(cmd.pat[i], cfg);
                        end
                    end
                end
                OP_TICK:
                begin
                    seg_hold_next   = pat_reg[scan_index_reg];
                    dig_hold_next   = cfg.dig_ah ? (off_hold | cur_bit)
                                                 : (off_hold & ~cur_bit);
                    scan_index_next = scan_index_reg + 2'd1;
                end
                default:
                begin
                    seg_hold_next = seg_hold_reg;
                end
            endcase
        end
        res_new.segment_lines  = seg_hold_next;
        res_new.digit_lines    = dig_hold_next & dig_mask;
        res_new.digit_pin_mask = dig_mask;
        res_new.next_digit     = scan_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                pat_reg[i] <= '0;
            end
            scan_index_reg <= '0;
            seg_hold_reg   <= '0;
            dig_hold_reg   <= '0;
        end
        else
        begin
            pat_reg        <= pat_next;
            scan_index_reg <= scan_index_next;
            seg_hold_reg   <= seg_hold_next;
            dig_hold_reg   <= dig_hold_next;
        end
    end

    // two-word result queue
    assign empty  = (rq_cnt_reg == 2'd0);
    assign rq_pop = pop && !empty;
    assign res    = rq_reg[rq_rd_ptr_reg];

    always_comb
    begin
        rq_wr_ptr_next = exec ? !rq_wr_ptr_reg : rq_wr_ptr_reg;
        rq_rd_ptr_next = rq_pop ? !rq_rd_ptr_reg : rq_rd_ptr_reg;
        rq_cnt_next    = rq_cnt_reg + 2'(exec) - 2'(rq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= 1'b0;
            rq_rd_ptr_reg <= 1'b0;
            rq_cnt_reg    <= 2'd0;
        end
        else
        begin
            rq_wr_ptr_reg <= rq_wr_ptr_next;
            rq_rd_ptr_reg <= rq_rd_ptr_next;
            rq_cnt_reg    <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rq_reg[rq_wr_ptr_reg] <= res_new;
        end
    end

    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && cmd.op == OP_TICK) |=> scan_index_reg == $past(scan_index_reg) + 2'd1)
        else $error("scan index did not advance on tick");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> (seg_hold_reg == $past(seg_hold_reg)
                   && dig_hold_reg == $past(dig_hold_reg)))
        else $error("port levels changed without a command");

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

>>> rtl/seven_segment_four_digit_mux.sv
// Four-digit multiplexed seven-segment driver. Commands enter through a queue
// interface (push/full) and each one yields exactly one result word
// (empty/pop) holding the segment port, the masked digit port, the set of
// driven digit pins and the digit the next tick enables. One command is taken
// per clock while full is low. A command's result word reaches the result
// ports after passing through the two-word command queue in front of the
// executing stage and the two-word result queue behind it. The executing
// stage stalls while the result queue is full. Once the command queue also
// holds two words, full rises. Digit patterns are stored in pin form and are
// converted when they are written, so segment polarity or segment pin-map
// changes only affect later writes. Configuration writes are always ready and
// take effect the next cycle; write them only while no command is in flight.
module seven_segment_four_digit_mux
    import ssdmux_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            func,
    input  logic [15:0]           value,
    input  logic [2:0]            dp_position,
    input  logic [2:0]            digit_position,
    input  logic [7:0]            logical_pattern,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            segment_lines,
    output logic [7:0]            digit_lines,
    output logic [7:0]            digit_pin_mask,
    output logic [1:0]            next_digit,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEG_ACTIVE_HIGH: cfg_next.seg_ah  = cfg_data[0];
                REG_DIG_ACTIVE_HIGH: cfg_next.dig_ah  = cfg_data[0];
                REG_SEG_PIN_MAP:     cfg_next.seg_map = cfg_data[23:0];
                REG_DIG_PIN_MAP:     cfg_next.dig_map = cfg_data[11:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_ah  <= 1'b1;
            cfg_reg.dig_ah  <= 1'b1;
            cfg_reg.seg_map <= SEG_PIN_MAP_RST;
            cfg_reg.dig_map <= DIG_PIN_MAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssdmux_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .func            (func),
        .value           (value),
        .dp_position     (dp_position),
        .digit_position  (digit_position),
        .logical_pattern (logical_pattern),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    ssdmux_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign segment_lines  = res.segment_lines;
    assign digit_lines    = res.digit_lines;
    assign digit_pin_mask = res.digit_pin_mask;
    assign next_digit     = res.next_digit;

endmodule
